// ===== hdl/lam3_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lam3_pkg: shared types and constants of the label adjacency matrix unit
// Channel payloads, configuration layout, queue job format and state codes.
// ----------------------------------------------------------------------------
package lam3_pkg;

   // Widest label any build can hold (MAX_LABELS up to 1024)
   localparam int LBL_W     = 11;
   localparam int NB_COUNT  = 7;
   localparam int WORD_BITS = 64;

   // Command codes of the request channel
   localparam logic [1:0] CMD_VOXEL  = 2'd0;
   localparam logic [1:0] CMD_READ   = 2'd1;
   localparam logic [1:0] CMD_CLEAR  = 2'd2;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   // Configuration register indexes and reset values
   localparam int          CSR_IDX_W      = 4;
   localparam int          CSR_DATA_W     = 16;
   localparam logic [3:0]  CSR_NUM_LABELS = 4'd0;
   localparam logic [3:0]  CSR_SIZE_X     = 4'd1;
   localparam logic [3:0]  CSR_SIZE_Y     = 4'd2;
   localparam logic [3:0]  CSR_SIZE_Z     = 4'd3;
   localparam logic [8:0]  RST_NUM_LABELS = 9'd100;
   localparam logic [8:0]  RST_SIZE_X     = 9'd256;
   localparam logic [8:0]  RST_SIZE_Y     = 9'd256;
   localparam logic [15:0] RST_SIZE_Z     = 16'd1;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [15:0] label_value;
      logic [7:0]  row_index;
      logic [1:0]  word_index;
   } req_type;

   typedef struct packed {
      logic [63:0] row_word;
      logic        frame_done;
      logic        label_error;
   } rsp_type;

   typedef struct packed {
      logic [8:0]  num_labels;
      logic [8:0]  size_x;
      logic [8:0]  size_y;
      logic [15:0] size_z;
   } cfg_type;

   typedef enum logic [1:0] {
      JOB_LINK,
      JOB_READ,
      JOB_CLEAR
   } job_kind_type;

   // One unit of work handed from the front end to the matrix engine
   typedef struct packed {
      job_kind_type                     kind;
      logic [LBL_W-1:0]                 lab;
      logic [NB_COUNT-1:0][LBL_W-1:0]   nb;
      logic [NB_COUNT-1:0]              mask;
      logic [7:0]                       row;
      logic [1:0]                       word;
      logic                             rd_ok;
      logic                             done;
      logic                             err;
   } job_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_UPPER,
      F_WRITE
   } front_state_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_FILL,
      B_RD,
      B_WR,
      B_RDATA
   } back_state_type;

endpackage
`default_nettype wire

// ===== hdl/lam3_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lam3_queue: job queue between front end and matrix engine
// Four-entry FIFO of jobs; lets either side stall without holding the other.
// ----------------------------------------------------------------------------
module lam3_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire lam3_pkg::job_type push_data,
   output logic                   full,
   input  wire logic              pop,
   output lam3_pkg::job_type      head,
   output logic                   empty
);
   import lam3_pkg::*;

   localparam int DEPTH = 4;
   localparam int PTR_W = 2;

   job_type          slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   count_ff, count_in;

   assign full  = (count_ff == (PTR_W+1)'(DEPTH));
   assign empty = (count_ff == '0);
   assign head  = slot_ff[rd_ptr_ff];

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push);
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
      count_in  = count_ff + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed job
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/lam3_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lam3_front: request front end
// Takes requests, tracks the voxel position, keeps the slice stores and
// turns each voxel into a list of neighbour labels for the matrix engine.
// ----------------------------------------------------------------------------
module lam3_front #(
   parameter int MAX_LABELS = 256,
   parameter int MAX_X      = 256,
   parameter int MAX_Y      = 256
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire lam3_pkg::cfg_type cfg,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire lam3_pkg::req_type req_data,
   output logic                   job_push,
   output lam3_pkg::job_type      job_data,
   input  wire logic              job_full
);
   import lam3_pkg::*;

   localparam int LW        = $clog2(MAX_LABELS + 1);
   localparam int PW        = 2 * LW;
   localparam int XW        = (MAX_X > 1) ? $clog2(MAX_X) : 1;
   localparam int YW        = (MAX_Y > 1) ? $clog2(MAX_Y) : 1;
   localparam int VOX       = MAX_X * MAX_Y;
   localparam int AW        = (VOX > 1) ? $clog2(VOX) : 1;
   localparam int ROW_WORDS = (MAX_LABELS + 63) / 64;

   front_state_type state_ff, state_in;
   logic [XW-1:0]   pos_x_ff, pos_x_in;
   logic [YW-1:0]   pos_y_ff, pos_y_in;
   logic [15:0]     pos_z_ff, pos_z_in;
   logic            done_ff, done_in;
   logic            err_ff, err_in;
   logic [LW-1:0]   lab_ff, lab_in;
   logic [AW-1:0]   here_ff, here_in;
   logic            xg_ff, xg_in, yg_ff, yg_in, zg_ff, zg_in;
   logic [PW-1:0]   here_pair_ff, here_pair_in;
   logic [PW-1:0]   left_pair_ff, left_pair_in;

   // Slice store: each entry holds {previous slice label, current slice label}
   logic [PW-1:0]   slice_mem [VOX];
   logic [PW-1:0]   rd_a_ff, rd_b_ff;
   logic [AW-1:0]   rd_a_addr, rd_b_addr;
   logic            wr_en;
   logic [PW-1:0]   wr_data;

   logic [LW-1:0]   nl_eff;
   logic [XW:0]     x_eff;
   logic [YW:0]     y_eff;
   logic [15:0]     z_eff;
   logic            lab_ok, req_acc;
   logic [AW-1:0]   cur_here;
   logic [XW:0]     x_nxt;
   logic [YW:0]     y_nxt;
   logic [16:0]     z_nxt;
   logic [NB_COUNT-1:0][LW-1:0] nb_lab;
   logic [NB_COUNT-1:0]         nb_cond;
   logic [NB_COUNT-1:0]         nb_en;

   // Clamp configuration to the supported range
   always_comb begin
      if (cfg.num_labels == '0) nl_eff = LW'(1);
      else if (int'(cfg.num_labels) > MAX_LABELS) nl_eff = LW'(MAX_LABELS);
      else nl_eff = LW'(cfg.num_labels);
      if (cfg.size_x == '0) x_eff = (XW+1)'(1);
      else if (int'(cfg.size_x) > MAX_X) x_eff = (XW+1)'(MAX_X);
      else x_eff = (XW+1)'(cfg.size_x);
      if (cfg.size_y == '0) y_eff = (YW+1)'(1);
      else if (int'(cfg.size_y) > MAX_Y) y_eff = (YW+1)'(MAX_Y);
      else y_eff = (YW+1)'(cfg.size_y);
      z_eff = (cfg.size_z == '0) ? 16'd1 : cfg.size_z;
   end

   assign req_stall = (state_ff != F_IDLE) || job_full;
   assign req_acc   = req_valid && !req_stall;
   assign lab_ok    = (req_data.label_value != '0) &&
                      (int'(req_data.label_value) <= int'(nl_eff));
   assign cur_here  = AW'(int'(pos_y_ff) * MAX_X + int'(pos_x_ff));
   assign x_nxt     = {1'b0, pos_x_ff} + (XW+1)'(1);
   assign y_nxt     = {1'b0, pos_y_ff} + (YW+1)'(1);
   assign z_nxt     = {1'b0, pos_z_ff} + 17'd1;

   // Gather the seven earlier voxels of the 2x2x2 cell
   always_comb begin
      nb_lab[0]  = left_pair_ff[LW-1:0];
      nb_cond[0] = xg_ff;
      nb_lab[1]  = rd_a_ff[LW-1:0];
      nb_cond[1] = yg_ff;
      nb_lab[2]  = rd_b_ff[LW-1:0];
      nb_cond[2] = xg_ff && yg_ff;
      nb_lab[3]  = here_pair_ff[LW-1:0];
      nb_cond[3] = zg_ff;
      nb_lab[4]  = left_pair_ff[PW-1:LW];
      nb_cond[4] = xg_ff && zg_ff;
      nb_lab[5]  = rd_a_ff[PW-1:LW];
      nb_cond[5] = yg_ff && zg_ff;
      nb_lab[6]  = rd_b_ff[PW-1:LW];
      nb_cond[6] = xg_ff && yg_ff && zg_ff;
      for (int k = 0; k < NB_COUNT; k++) begin
         nb_en[k] = nb_cond[k] && (lab_ff != '0) && (nb_lab[k] != '0) &&
                    (nb_lab[k] <= nl_eff) && (nb_lab[k] != lab_ff);
      end
   end

   // Sequence requests and build jobs
   always_comb begin
      state_in     = state_ff;
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      pos_z_in     = pos_z_ff;
      done_in      = done_ff;
      err_in       = err_ff;
      lab_in       = lab_ff;
      here_in      = here_ff;
      xg_in        = xg_ff;
      yg_in        = yg_ff;
      zg_in        = zg_ff;
      here_pair_in = here_pair_ff;
      left_pair_in = left_pair_ff;
      rd_a_addr    = cur_here;
      rd_b_addr    = cur_here - AW'(1);
      wr_en        = 1'b0;
      wr_data      = {here_pair_ff[LW-1:0], lab_ff};
      job_push     = 1'b0;
      job_data     = '0;
      unique case (state_ff)
         F_IDLE: begin
            if (req_acc) begin
               case (req_data.cmd)
                  CMD_VOXEL: begin
                     if (!done_ff) begin
                        lab_in   = lab_ok ? LW'(req_data.label_value) : '0;
                        err_in   = err_ff || !lab_ok;
                        here_in  = cur_here;
                        xg_in    = (pos_x_ff != '0);
                        yg_in    = (pos_y_ff != '0);
                        zg_in    = (pos_z_ff != '0);
                        state_in = F_UPPER;
                        pos_x_in = x_nxt[XW-1:0];
                        if (x_nxt >= x_eff) begin
                           pos_x_in = '0;
                           pos_y_in = y_nxt[YW-1:0];
                           if (y_nxt >= y_eff) begin
                              pos_y_in = '0;
                              pos_z_in = z_nxt[15:0];
                              if (z_nxt >= {1'b0, z_eff}) begin
                                 pos_z_in = '0;
                                 done_in  = 1'b1;
                              end
                           end
                        end
                     end
                  end
                  CMD_READ: begin
                     job_push       = 1'b1;
                     job_data.kind  = JOB_READ;
                     job_data.row   = req_data.row_index;
                     job_data.word  = req_data.word_index;
                     job_data.rd_ok = (int'(req_data.row_index) < int'(nl_eff)) &&
                                      (int'(req_data.word_index) < ROW_WORDS);
                     job_data.done  = done_ff;
                     job_data.err   = err_ff;
                  end
                  CMD_CLEAR: begin
                     job_push      = 1'b1;
                     job_data.kind = JOB_CLEAR;
                     pos_x_in      = '0;
                     pos_y_in      = '0;
                     pos_z_in      = '0;
                     done_in       = 1'b0;
                     err_in        = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         F_UPPER: begin
            // Hold this voxel's and the left voxel's entries, fetch the row above
            here_pair_in = rd_a_ff;
            left_pair_in = rd_b_ff;
            rd_a_addr    = here_ff - AW'(MAX_X);
            rd_b_addr    = here_ff - AW'(MAX_X + 1);
            state_in     = F_WRITE;
         end
         F_WRITE: begin
            wr_en         = 1'b1;
            job_push      = (nb_en != '0);
            job_data.kind = JOB_LINK;
            job_data.lab  = LBL_W'(lab_ff);
            job_data.mask = nb_en;
            for (int k = 0; k < NB_COUNT; k++) begin
               job_data.nb[k] = LBL_W'(nb_lab[k]);
            end
            state_in = F_IDLE;
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         pos_x_ff <= '0;
         pos_y_ff <= '0;
         pos_z_ff <= '0;
         done_ff  <= 1'b0;
         err_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
         pos_z_ff <= pos_z_in;
         done_ff  <= done_in;
         err_ff   <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      lab_ff       <= lab_in;
      here_ff      <= here_in;
      xg_ff        <= xg_in;
      yg_ff        <= yg_in;
      zg_ff        <= zg_in;
      here_pair_ff <= here_pair_in;
      left_pair_ff <= left_pair_in;
   end

   // Slice store: two registered reads, one write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slice_mem[here_ff] <= wr_data;
      end
      rd_a_ff <= slice_mem[rd_a_addr];
      rd_b_ff <= slice_mem[rd_b_addr];
   end

endmodule
`default_nettype wire

// ===== hdl/lam3_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lam3_back: adjacency matrix engine
// Owns the adjacency memory; sets matrix bits by read-modify-write, serves
// word reads into the output register and clears rows through valid bits.
// ----------------------------------------------------------------------------
module lam3_back #(
   parameter int MAX_LABELS = 256
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              job_empty,
   input  wire lam3_pkg::job_type job_head,
   output logic                   job_pop,
   output logic                   rsp_valid,
   output lam3_pkg::rsp_type      rsp_data,
   input  wire logic              rsp_stall
);
   import lam3_pkg::*;

   localparam int RW        = $clog2(MAX_LABELS);
   localparam int ROW_WORDS = (MAX_LABELS + 63) / 64;
   localparam int WW        = (ROW_WORDS > 1) ? $clog2(ROW_WORDS) : 1;
   localparam int DEPTH     = MAX_LABELS * ROW_WORDS;
   localparam int MW        = $clog2(DEPTH);

   back_state_type           state_ff, state_in;
   job_type                  job_ff, job_in;
   logic [NB_COUNT-1:0]      mask_ff, mask_in;
   logic                     dir_ff, dir_in;
   logic [WW-1:0]            fill_ff, fill_in;
   logic [MAX_LABELS-1:0]    row_valid_ff, row_valid_in;
   logic                     rd_hit_ff, rd_hit_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_ff, rsp_in;

   logic [WORD_BITS-1:0]     adj_mem [DEPTH];
   logic [WORD_BITS-1:0]     adj_rd_ff;
   logic [MW-1:0]            mem_raddr, mem_waddr;
   logic                     mem_wen;
   logic [WORD_BITS-1:0]     mem_wdata;

   logic [2:0]               sel;
   logic [LBL_W-1:0]         nbl, lab_a, lab_b, col_l;
   logic [RW-1:0]            row_l, row_r;
   logic [MW-1:0]            link_addr, fill_addr, read_addr;
   logic                     out_free;
   logic [NB_COUNT-1:0]      mask_left;

   // Pick the lowest pending neighbour and form its matrix address
   always_comb begin
      sel = 3'd0;
      for (int k = NB_COUNT - 1; k >= 0; k--) begin
         if (mask_ff[k]) sel = 3'(k);
      end
      nbl       = job_ff.nb[sel];
      lab_a     = dir_ff ? nbl : job_ff.lab;
      lab_b     = dir_ff ? job_ff.lab : nbl;
      row_l     = RW'(lab_a - LBL_W'(1));
      col_l     = lab_b - LBL_W'(1);
      link_addr = MW'(int'(row_l) * ROW_WORDS + int'(col_l >> 6));
      fill_addr = MW'(int'(row_l) * ROW_WORDS + int'(fill_ff));
      row_r     = RW'(job_head.row);
      read_addr = MW'(int'(row_r) * ROW_WORDS + int'(job_head.word));
      mask_left = mask_ff & ~(NB_COUNT'(1) << sel);
   end

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Run jobs
   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      mask_in      = mask_ff;
      dir_in       = dir_ff;
      fill_in      = fill_ff;
      row_valid_in = row_valid_ff;
      rd_hit_in    = rd_hit_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      job_pop      = 1'b0;
      mem_raddr    = link_addr;
      mem_wen      = 1'b0;
      mem_waddr    = link_addr;
      mem_wdata    = adj_rd_ff | (WORD_BITS'(1) << col_l[5:0]);
      unique case (state_ff)
         B_IDLE: begin
            if (!job_empty) begin
               case (job_head.kind)
                  JOB_CLEAR: begin
                     job_pop      = 1'b1;
                     row_valid_in = '0;
                  end
                  JOB_READ: begin
                     if (out_free) begin
                        job_pop   = 1'b1;
                        job_in    = job_head;
                        mem_raddr = read_addr;
                        rd_hit_in = job_head.rd_ok && row_valid_ff[row_r];
                        state_in  = B_RDATA;
                     end
                  end
                  JOB_LINK: begin
                     job_pop  = 1'b1;
                     job_in   = job_head;
                     mask_in  = job_head.mask;
                     dir_in   = 1'b0;
                     state_in = B_RD;
                  end
                  default: begin
                     job_pop = 1'b1;
                  end
               endcase
            end
         end
         B_RD: begin
            // A row untouched since the last clear is zeroed before its first update
            if (!row_valid_ff[row_l]) begin
               fill_in  = '0;
               state_in = B_FILL;
            end else begin
               state_in = B_WR;
            end
         end
         B_FILL: begin
            mem_wen   = 1'b1;
            mem_waddr = fill_addr;
            mem_wdata = '0;
            fill_in   = fill_ff + WW'(1);
            if (fill_ff == WW'(ROW_WORDS - 1)) begin
               row_valid_in[row_l] = 1'b1;
               state_in            = B_RD;
            end
         end
         B_WR: begin
            mem_wen = 1'b1;
            if (!dir_ff) begin
               dir_in   = 1'b1;
               state_in = B_RD;
            end else begin
               dir_in   = 1'b0;
               mask_in  = mask_left;
               state_in = (mask_left == '0) ? B_IDLE : B_RD;
            end
         end
         B_RDATA: begin
            rsp_in.row_word    = rd_hit_ff ? adj_rd_ff : '0;
            rsp_in.frame_done  = job_ff.done;
            rsp_in.label_error = job_ff.err;
            rsp_valid_in       = 1'b1;
            state_in           = B_IDLE;
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         row_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
         mask_ff      <= '0;
         dir_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_valid_ff <= row_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         mask_ff      <= mask_in;
         dir_ff       <= dir_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff    <= job_in;
      fill_ff   <= fill_in;
      rd_hit_ff <= rd_hit_in;
      rsp_ff    <= rsp_in;
   end

   // Adjacency memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (mem_wen) begin
         adj_mem[mem_waddr] <= mem_wdata;
      end
      adj_rd_ff <= adj_mem[mem_raddr];
   end

endmodule
`default_nettype wire

// ===== hdl/label_adjacency_matrix_3d_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// label_adjacency_matrix_3d_unit: region adjacency matrix of a label volume
// Configuration registers, front end, job queue and matrix engine.
// ----------------------------------------------------------------------------
// Voxels arrive in raster order (x, then y, then z); each is compared with the
// seven earlier voxels of its 2x2x2 cell and the touching labels are recorded
// in a symmetric bit matrix, read back one 64-bit word per read request. The
// front end takes a read or clear request in its idle state and a voxel through
// its idle, upper and write states, as the two-port slice store must deliver
// four neighbour entries. Behind a four-entry queue the matrix engine sets each
// matrix bit by read-modify-write on its one-read, one-write memory, in its read
// and write states, once per touching neighbour voxel and direction (equal labels
// are not merged); a row first touched after a clear is first zeroed word by word.
// A read passes through the read-data state into the output register. Reset and
// clear drop the row valid bits; no clearing pass is run.
// ----------------------------------------------------------------------------
module label_adjacency_matrix_3d_unit #(
   parameter int MAX_LABELS = 256,
   parameter int MAX_X      = 256,
   parameter int MAX_Y      = 256
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire lam3_pkg::req_type              req_data,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output lam3_pkg::rsp_type                   rsp_data,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [lam3_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [lam3_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import lam3_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    job_push, job_full, job_pop, job_empty;
   job_type job_data, job_head;

   assign csr_ready = 1'b1;

   // Decode register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_NUM_LABELS: cfg_in.num_labels = csr_wdata[8:0];
            CSR_SIZE_X:     cfg_in.size_x     = csr_wdata[8:0];
            CSR_SIZE_Y:     cfg_in.size_y     = csr_wdata[8:0];
            CSR_SIZE_Z:     cfg_in.size_z     = csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.num_labels <= RST_NUM_LABELS;
         cfg_ff.size_x     <= RST_SIZE_X;
         cfg_ff.size_y     <= RST_SIZE_Y;
         cfg_ff.size_z     <= RST_SIZE_Z;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lam3_front #(
      .MAX_LABELS (MAX_LABELS),
      .MAX_X      (MAX_X),
      .MAX_Y      (MAX_Y)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .job_push  (job_push),
      .job_data  (job_data),
      .job_full  (job_full)
   );

   lam3_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_data),
      .full      (job_full),
      .pop       (job_pop),
      .head      (job_head),
      .empty     (job_empty)
   );

   lam3_back #(
      .MAX_LABELS (MAX_LABELS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_empty (job_empty),
      .job_head  (job_head),
      .job_pop   (job_pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

endmodule
`default_nettype wire

// ===== hdl/lam3_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lam3_checker: port-level checks of the adjacency matrix unit
// Watches the top-level ports; attached to the top level by bind.
// ----------------------------------------------------------------------------
module lam3_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_stall,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire lam3_pkg::rsp_type rsp_data,
   input wire logic              csr_ready
);

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed or dropped");

   // Drop any pending result on reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Front end and queue come out of reset ready for a transfer
   a_req_reset: assert property (@(posedge clock)
      reset |=> !req_stall)
      else $error("request stalled after reset");

   // The configuration port is ready whenever a request is valid
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      req_valid |-> csr_ready)
      else $error("configuration port not ready");

endmodule

bind label_adjacency_matrix_3d_unit lam3_checker u_lam3_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data),
   .csr_ready (csr_ready)
);
`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench of the label adjacency matrix unit
// Streams label volumes, reads and clears through the request channel and
// checks every read word against a local model of the adjacency matrix.
// ----------------------------------------------------------------------------
module tb;
   import lam3_pkg::*;

   localparam int MAXL      = 256;
   localparam int MAXX      = 256;
   localparam int MAXY      = 256;
   localparam int ROWW      = (MAXL + 63) / 64;
   localparam int CYC_LIMIT = 1000000;
   localparam int DRAIN     = 200;
   localparam int REQ_W     = $bits(req_type);

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   label_adjacency_matrix_3d_unit u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // Model state
   logic [63:0] adj_bits [MAXL*ROWW];
   logic [15:0] cur_slice [MAXX*MAXY];
   logic [15:0] prev_slice [MAXX*MAXY];
   int unsigned pos_x, pos_y, pos_z;
   bit          done_flag, error_flag;
   int unsigned cfg_labels, cfg_x, cfg_y, cfg_z;

   rsp_type     word_queue[$];
   bit          failed = 1'b0;
   int          send_idle = 0;
   int          recv_idle = 0;
   int unsigned cycles = 0;

   // Clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYC_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   function automatic int unsigned eff_labels();
      if (cfg_labels < 1) return 1;
      return (cfg_labels > MAXL) ? MAXL : cfg_labels;
   endfunction

   function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
      if (v < 1) return 1;
      return (v > hi) ? hi : v;
   endfunction

   function automatic void clear_model();
      foreach (adj_bits[i]) adj_bits[i] = '0;
      pos_x = 0; pos_y = 0; pos_z = 0;
      done_flag = 1'b0; error_flag = 1'b0;
   endfunction

   function automatic void link_pair(int unsigned a, int unsigned b);
      int unsigned nl;
      nl = eff_labels();
      if (a == 0 || b == 0 || a > nl || b > nl || a == b) return;
      adj_bits[(a-1)*ROWW + ((b-1) >> 6)][(b-1) & 63] = 1'b1;
      adj_bits[(b-1)*ROWW + ((a-1) >> 6)][(a-1) & 63] = 1'b1;
   endfunction

   // Advance the model by one voxel
   function automatic void take_voxel(int unsigned label);
      int unsigned x, y, here, lab;
      if (done_flag) return;
      x = (pos_x >= MAXX) ? MAXX - 1 : pos_x;
      y = (pos_y >= MAXY) ? MAXY - 1 : pos_y;
      here = y * MAXX + x;
      lab = label;
      if (lab == 0 || lab > eff_labels()) begin
         error_flag = 1'b1;
         lab = 0;
      end
      prev_slice[here] = cur_slice[here];
      cur_slice[here] = 16'(lab);
      if (lab != 0) begin
         if (x > 0) link_pair(lab, cur_slice[here-1]);
         if (y > 0) link_pair(lab, cur_slice[here-MAXX]);
         if (x > 0 && y > 0) link_pair(lab, cur_slice[here-MAXX-1]);
         if (pos_z > 0) begin
            link_pair(lab, prev_slice[here]);
            if (x > 0) link_pair(lab, prev_slice[here-1]);
            if (y > 0) link_pair(lab, prev_slice[here-MAXX]);
            if (x > 0 && y > 0) link_pair(lab, prev_slice[here-MAXX-1]);
         end
      end
      pos_x++;
      if (pos_x >= clamp_dim(cfg_x, MAXX)) begin
         pos_x = 0; pos_y++;
         if (pos_y >= clamp_dim(cfg_y, MAXY)) begin
            pos_y = 0; pos_z++;
            if (pos_z >= ((cfg_z < 1) ? 1 : cfg_z)) begin
               pos_z = 0; done_flag = 1'b1;
            end
         end
      end
   endfunction

   // Expected outcome of one accepted request
   function automatic void predict_request(req_type r);
      rsp_type e;
      case (r.cmd)
         CMD_VOXEL: take_voxel(r.label_value);
         CMD_CLEAR: clear_model();
         CMD_READ: begin
            e.row_word = '0;
            if (r.row_index < eff_labels() && r.word_index < ROWW)
               e.row_word = adj_bits[r.row_index*ROWW + r.word_index];
            e.frame_done  = done_flag;
            e.label_error = error_flag;
            word_queue.push_back(e);
         end
         default: ;
      endcase
   endfunction

   // Receiver stall, refreshed at each falling edge
   always @(negedge clock) begin
      rsp_stall <= (recv_idle > 0) && ($urandom_range(99) < recv_idle);
   end

   // Check each result transfer against the oldest expected word
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (word_queue.size() == 0) begin
            $display("%0t: unexpected result, actual %h", $time, rsp_data);
            failed = 1'b1;
         end else begin
            e = word_queue.pop_front();
            if (rsp_data.row_word !== e.row_word) begin
               $display("%0t: row_word expected %h actual %h",
                        $time, e.row_word, rsp_data.row_word);
               failed = 1'b1;
            end
            if (rsp_data.frame_done !== e.frame_done) begin
               $display("%0t: frame_done expected %b actual %b",
                        $time, e.frame_done, rsp_data.frame_done);
               failed = 1'b1;
            end
            if (rsp_data.label_error !== e.label_error) begin
               $display("%0t: label_error expected %b actual %b",
                        $time, e.label_error, rsp_data.label_error);
               failed = 1'b1;
            end
         end
      end
   end

   // Send one request and hold it until the transfer; valid stays up for a
   // following request and is dropped by whoever idles next
   task automatic send_request(req_type r);
      while ((send_idle > 0) && ($urandom_range(99) < send_idle)) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_request(r);
      @(negedge clock);
   endtask

   task automatic send_voxel(int unsigned label);
      req_type r;
      r = '0; r.cmd = CMD_VOXEL; r.label_value = 16'(label);
      r.row_index = 8'($urandom); r.word_index = 2'($urandom);
      send_request(r);
   endtask

   task automatic send_read(int unsigned row, int unsigned word);
      req_type r;
      r = '0; r.cmd = CMD_READ; r.row_index = 8'(row); r.word_index = 2'(word);
      r.label_value = 16'($urandom);
      send_request(r);
   endtask

   task automatic send_clear();
      req_type r;
      r = REQ_W'($urandom); r.cmd = CMD_CLEAR;
      send_request(r);
   endtask

   // Drain all expected words, then let the engine settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (word_queue.size() != 0) @(negedge clock);
      repeat (DRAIN) @(negedge clock);
   endtask

   // Write one register; valid stays up for a following write
   task automatic write_csr(logic [3:0] idx, int unsigned value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(value);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_NUM_LABELS: cfg_labels = value & 'h1FF;
         CSR_SIZE_X:     cfg_x = value & 'h1FF;
         CSR_SIZE_Y:     cfg_y = value & 'h1FF;
         CSR_SIZE_Z:     cfg_z = value & 'hFFFF;
         default: ;
      endcase
      @(negedge clock);
   endtask

   // New geometry from a clean state; the clear resets positions
   task automatic set_geometry(int unsigned nl, int unsigned sx, int unsigned sy,
                               int unsigned sz);
      wait_idle();
      write_csr(CSR_NUM_LABELS, nl);
      write_csr(CSR_SIZE_X, sx);
      write_csr(CSR_SIZE_Y, sy);
      write_csr(CSR_SIZE_Z, sz);
      csr_valid <= 1'b0;
      send_clear();
   endtask

   // Read back the leading rows in full
   task automatic read_all_rows();
      for (int i = 0; i < eff_labels() && i < 16; i++)
         for (int w = 0; w <= (eff_labels() - 1) / 64; w++) send_read(i, w);
   endtask

   // Directed: extremes, every command and the special cases
   task automatic test_directed();
      req_type r;
      send_read(0, 0);
      set_geometry(256, 2, 2, 2);
      send_voxel(1); send_voxel(256); send_voxel(0); send_voxel(65535);
      send_voxel(200); send_voxel(3);
      send_read(0, 3); send_read(255, 0);
      send_voxel(3); send_voxel(7);
      send_voxel(9);              // ignored after frame done
      send_read(6, 0); send_read(2, 0); send_read(199, 3);
      r = '1; r.cmd = CMD_UNUSED; send_request(r);
      send_read(255, 3);
      send_clear();
      send_read(0, 3);
      set_geometry(1, 1, 1, 0);
      send_voxel(1); send_voxel(2);
      send_read(0, 0); send_read(1, 0);
   endtask

   // Random: mostly whole frames with random labels, some reads and noise
   task automatic test_random(int unsigned items);
      int unsigned n, nl, sx, sy, sz;
      n = 0;
      while (n < items) begin
         nl = ($urandom_range(9) == 0) ? 256 : $urandom_range(2, 12);
         sx = $urandom_range(1, 5); sy = $urandom_range(1, 4);
         sz = $urandom_range(1, 3);
         if ($urandom_range(11) == 0) sx = 256;
         if (sx == 256) begin sy = 1; sz = 1; end
         set_geometry(nl, sx, sy, sz);
         for (int v = 0; v < sx*sy*sz && v < 40; v++) begin
            case ($urandom_range(19))
               0: send_voxel($urandom);
               1: send_voxel(0);
               2: send_read($urandom, $urandom);
               default: send_voxel($urandom_range(1, nl));
            endcase
            n++;
         end
         if ($urandom_range(3) == 0) wait_idle();   // sender holds off
         for (int k = 0; k < 6; k++) begin
            send_read($urandom_range(0, (nl > 12) ? 255 : nl), $urandom);
            n++;
         end
      end
      read_all_rows();
   endtask

   initial begin
      cfg_labels = RST_NUM_LABELS; cfg_x = RST_SIZE_X;
      cfg_y = RST_SIZE_Y; cfg_z = RST_SIZE_Z;
      clear_model();
      foreach (cur_slice[i]) begin cur_slice[i] = '0; prev_slice[i] = '0; end
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      send_idle = 17; recv_idle = 48;
      test_directed();
      test_random(120);
      send_idle = 48; recv_idle = 17;
      test_random(120);
      send_idle = 0; recv_idle = 0;
      test_random(120);
      wait_idle();
      if (!failed) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule

// ===== label_adjacency_matrix_3d_unit.f =====
hdl/lam3_pkg.sv
hdl/lam3_queue.sv
hdl/lam3_front.sv
hdl/lam3_back.sv
hdl/label_adjacency_matrix_3d_unit.sv
hdl/lam3_checker.sv
dv/tb.sv
